[rtl/dgs_pkg.sv]
// Package with shared types, constants and codes for the group statistics block.
package dgs_pkg;

  localparam int SampleBitsDef = 24;
  localparam int GroupCountBitsDef = 16;
  localparam int ValBits = 41;
  localparam int SqBits = 64;
  localparam int RowBits = 16;
  localparam int CfgIdxBits = 2;
  localparam int CfgDataBits = 16;

  // Register indexes.
  localparam logic [CfgIdxBits-1:0] REG_GROUP_SIZE = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_STAT_MODE = 2'd1;
  localparam logic [CfgIdxBits-1:0] REG_MAX_ROWS = 2'd2;

  // Statistic codes; undefined codes act as sum.
  localparam logic [2:0] MODE_AVG = 3'd0;
  localparam logic [2:0] MODE_MIN = 3'd1;
  localparam logic [2:0] MODE_MAX = 3'd2;
  localparam logic [2:0] MODE_RMS = 3'd3;
  localparam logic [2:0] MODE_SUM = 3'd4;

  // Job handed from the front end to the back end through the queue.
  typedef struct packed {
    logic                has_value;
    logic [2:0]          mode;
    logic signed [ValBits-1:0] acc;
    logic [SqBits-1:0]   sq;
    logic [RowBits-1:0]  n;
    logic [RowBits-1:0]  row;
    logic                frame_done;
    logic [RowBits-1:0]  row_count;
  } job_t;

  // Result beat.
  typedef struct packed {
    logic                has_value;
    logic signed [ValBits-1:0] stat_value;
    logic [RowBits-1:0]  row_index;
    logic                frame_done;
    logic [RowBits-1:0]  row_count;
  } result_t;

endpackage

[rtl/dgs_if.sv]
// Stream and configuration channel interfaces.
interface dgs_in_if #(parameter int SampleBits = 24) (input logic clk);
  logic valid;
  logic ready;
  logic signed [SampleBits-1:0] sample;
  logic frame_end;
  modport source (output valid, sample, frame_end, input ready);
  modport sink (input valid, sample, frame_end, output ready);
endinterface

interface dgs_out_if (input logic clk);
  logic valid;
  logic ready;
  logic has_value;
  logic signed [40:0] stat_value;
  logic [15:0] row_index;
  logic frame_done;
  logic [15:0] row_count;
  modport source (output valid, has_value, stat_value, row_index, frame_done, row_count,
                  input ready);
  modport sink (input valid, has_value, stat_value, row_index, frame_done, row_count,
                output ready);
endinterface

interface dgs_cfg_if (input logic clk);
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/dgs_front.sv]
// Front end: accumulates samples into groups and emits one job per result.
module dgs_front #(
  parameter int SampleBits = dgs_pkg::SampleBitsDef,
  parameter int GroupCountBits = dgs_pkg::GroupCountBitsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SampleBits-1:0]  sample,
  input  logic                          frame_end,
  input  logic [15:0]                   group_size,
  input  logic [2:0]                    stat_mode,
  input  logic [15:0]                   max_rows,
  output logic                          job_valid,
  input  logic                          job_ready,
  output dgs_pkg::job_t                 job
);
  import dgs_pkg::*;

  localparam logic signed [ValBits-1:0] VMax = {1'b0, {(ValBits-1){1'b1}}};
  localparam logic signed [ValBits-1:0] VMin = {1'b1, {(ValBits-1){1'b0}}};

  logic [RowBits-1:0] samples_in_group;
  logic signed [ValBits-1:0] value_accumulator;
  logic [SqBits-1:0] square_accumulator;
  logic [RowBits-1:0] rows_given;

  logic [RowBits-1:0] n;
  logic signed [ValBits-1:0] x;
  logic [SampleBits-1:0] mag;
  logic [SqBits-1:0] sq;
  logic signed [ValBits:0] sum_w;
  logic [SqBits:0] sq_w;
  logic signed [ValBits-1:0] acc_next;
  logic [SqBits-1:0] sq_next;
  logic [RowBits:0] cnt_next;
  logic complete, give, accept;

  // Group length with zero taken as one.
  always_comb begin
    n = RowBits'(group_size & RowBits'((32'd1 << GroupCountBits) - 32'd1));
    if (n == '0) n = RowBits'(1);
  end

  assign x = ValBits'(sample);
  assign mag = sample[SampleBits-1] ? SampleBits'(-sample) : sample;
  assign sq = SqBits'(mag) * SqBits'(mag);

  // Accumulate under the mode in force for this sample.
  always_comb begin
    sum_w = (ValBits+1)'(value_accumulator) + (ValBits+1)'(x);
    sq_w = (SqBits+1)'(square_accumulator) + (SqBits+1)'(sq);
    if (samples_in_group == '0) begin
      acc_next = x;
      sq_next = sq;
    end else begin
      case (stat_mode)
        MODE_MIN: acc_next = (x < value_accumulator) ? x : value_accumulator;
        MODE_MAX: acc_next = (x > value_accumulator) ? x : value_accumulator;
        default: begin
          if (sum_w > (ValBits+1)'(VMax)) acc_next = VMax;
          else if (sum_w < (ValBits+1)'(VMin)) acc_next = VMin;
          else acc_next = sum_w[ValBits-1:0];
        end
      endcase
      sq_next = sq_w[SqBits] ? '1 : sq_w[SqBits-1:0];
    end
  end

  assign cnt_next = (RowBits+1)'(samples_in_group) + (RowBits+1)'(1);
  assign complete = cnt_next >= (RowBits+1)'(n);
  assign give = complete && (rows_given < max_rows);

  // The front stalls only when it has a job and the queue is full.
  assign in_ready = job_ready || !(give || frame_end);
  assign accept = in_valid && in_ready;
  assign job_valid = in_valid && (give || frame_end);

  always_comb begin
    job.has_value = give;
    job.mode = stat_mode;
    job.acc = acc_next;
    job.sq = sq_next;
    job.n = n;
    job.row = give ? rows_given : '0;
    job.frame_done = frame_end;
    job.row_count = frame_end ? (give ? rows_given + RowBits'(1) : rows_given) : '0;
  end

  // Group state.
  always_ff @(posedge clk) begin
    if (rst) begin
      samples_in_group <= '0;
      value_accumulator <= '0;
      square_accumulator <= '0;
      rows_given <= '0;
    end else if (accept) begin
      if (complete || frame_end) begin
        samples_in_group <= '0;
        value_accumulator <= '0;
        square_accumulator <= '0;
      end else begin
        samples_in_group <= cnt_next[RowBits-1:0];
        value_accumulator <= acc_next;
        square_accumulator <= sq_next;
      end
      if (frame_end) rows_given <= '0;
      else if (give) rows_given <= rows_given + RowBits'(1);
    end
  end

  a_count_below_n: assert property (@(posedge clk) disable iff (rst)
    samples_in_group < n || $past(group_size) != group_size || $past(rst))
    else $error("group count reached group length");
  a_frame_clears: assert property (@(posedge clk) disable iff (rst)
    accept && frame_end |=> rows_given == '0 && samples_in_group == '0)
    else $error("frame end left state");
  a_row_limit: assert property (@(posedge clk) disable iff (rst)
    job_valid && job.has_value |-> job.row < max_rows)
    else $error("row beyond limit");

endmodule

[rtl/dgs_queue.sv]
// Two-entry queue between front and back end.
module dgs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  dgs_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output dgs_pkg::job_t rd_data
);
  import dgs_pkg::*;

  job_t mem [2];
  logic wp, rp;
  logic [1:0] count;
  logic wr, rd;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end

  // Pointers and fill.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      count <= count + 2'(wr) - 2'(rd);
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overfilled");
  a_ptr: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wp == rp)
    else $error("queue pointers disagree with fill");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    wr && !rd |=> count == $past(count) + 2'd1)
    else $error("queue fill not counted");

endmodule

[rtl/dgs_back.sv]
// Back end: bit-serial division by group length (avg, rms), square root (rms).
module dgs_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  dgs_pkg::job_t job,
  output logic          res_valid,
  input  logic          res_ready,
  output dgs_pkg::result_t res
);
  import dgs_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_OUT = 3'd3;

  logic [2:0] state;
  job_t cur;
  logic [SqBits-1:0] quo;
  logic [SqBits:0] rem;
  logic [6:0] step;
  logic neg;
  logic [SqBits-1:0] sa, sres, sbit;
  logic [SqBits-1:0] st_rem_shift;
  logic [SqBits:0] rem_sh;
  logic [SqBits-1:0] sum_rb;
  logic signed [ValBits-1:0] value_q;

  assign job_ready = state == ST_IDLE;
  assign res_valid = state == ST_OUT;
  assign rem_sh = {rem[SqBits-1:0], quo[SqBits-1]};
  assign sum_rb = sres + sbit;
  assign st_rem_shift = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (job_valid) begin
          cur <= job;
          rem <= '0;
          step <= 7'd0;
          if (job.has_value && job.mode == MODE_AVG) begin
            neg <= job.acc[ValBits-1];
            quo <= SqBits'($unsigned(job.acc[ValBits-1] ? -job.acc : job.acc));
            state <= ST_DIV;
          end else if (job.has_value && job.mode == MODE_RMS) begin
            neg <= 1'b0;
            quo <= job.sq;
            state <= ST_DIV;
          end else begin
            value_q <= job.has_value ? job.acc : '0;
            state <= ST_OUT;
          end
        end
        // Restoring division, one quotient bit per cycle.
        ST_DIV: begin
          if (rem_sh >= (SqBits+1)'(cur.n)) begin
            rem <= rem_sh - (SqBits+1)'(cur.n);
            quo <= {quo[SqBits-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[SqBits-2:0], 1'b0};
          end
          step <= step + 7'd1;
          if (step == 7'(SqBits-1)) begin
            if (cur.mode == MODE_RMS) begin
              state <= ST_SQRT;
              sres <= '0;
              sbit <= {2'b01, {(SqBits-2){1'b0}}};
            end else begin
              state <= ST_OUT;
            end
          end
        end
        // Digit-by-digit square root, two bits per cycle.
        ST_SQRT: begin
          if (sbit == '0) begin
            state <= ST_OUT;
          end else begin
            if ({1'b0, quo} >= {1'b0, sum_rb} && quo >= sum_rb) begin
              quo <= quo - sum_rb;
              sres <= (sres >> 1) + sbit;
            end else begin
              sres <= sres >> 1;
            end
            sbit <= sbit >> 2;
          end
        end
        ST_OUT: if (res_ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Final value selection.
  always_comb begin
    res.has_value = cur.has_value;
    res.row_index = cur.row;
    res.frame_done = cur.frame_done;
    res.row_count = cur.row_count;
    if (!cur.has_value) res.stat_value = '0;
    else if (cur.mode == MODE_AVG)
      res.stat_value = neg ? -ValBits'(quo) : ValBits'(quo);
    else if (cur.mode == MODE_RMS) res.stat_value = ValBits'(sres) | ValBits'(st_rem_shift);
    else res.stat_value = value_q;
  end

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped");
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    job_ready |-> !res_valid)
    else $error("back end busy and idle at once");
  a_step: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> step < 7'(SqBits))
    else $error("division overran");

endmodule

[rtl/decimating_group_statistics.sv]
// Top level of the decimating group statistics block.
// Samples are taken by the front end, which keeps the running sum, minimum or
// maximum, as the mode selects, and the sum of squares. Each result (a finished
// group within max_rows, or a frame end) goes as a job through a two-entry queue
// to the back end. Minimum, maximum, sum and pure frame-end results pass there
// from idle straight to the output state; average goes through the 64-step
// bit-serial divider, and rms through the divider and a bit-serial square root.
// So the input runs at one sample per cycle as long as the back end keeps up with
// the results; the serial divider sets the group-rate limit.
module decimating_group_statistics #(
  parameter int SampleBits = dgs_pkg::SampleBitsDef,
  parameter int GroupCountBits = dgs_pkg::GroupCountBitsDef
) (
  input logic clk,
  input logic rst,
  dgs_in_if.sink   in_ch,
  dgs_out_if.source out_ch,
  dgs_cfg_if.sink  cfg
);
  import dgs_pkg::*;

  logic [15:0] group_size;
  logic [2:0] stat_mode;
  logic [15:0] max_rows;
  logic fj_valid, fj_ready, bj_valid, bj_ready;
  job_t fj, bj;
  result_t res;

  // Configuration registers.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= 16'd8;
      stat_mode <= MODE_AVG;
      max_rows <= 16'd1024;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_GROUP_SIZE: group_size <= cfg.data;
        REG_STAT_MODE: stat_mode <= cfg.data[2:0];
        REG_MAX_ROWS: max_rows <= cfg.data;
        default: ;
      endcase
    end
  end

  dgs_front #(.SampleBits(SampleBits), .GroupCountBits(GroupCountBits)) u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .sample(in_ch.sample), .frame_end(in_ch.frame_end),
    .group_size, .stat_mode, .max_rows,
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  dgs_queue u_queue (
    .clk, .rst,
    .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
  );

  dgs_back u_back (
    .clk, .rst,
    .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res
  );

  assign out_ch.has_value = res.has_value;
  assign out_ch.stat_value = res.stat_value;
  assign out_ch.row_index = res.row_index;
  assign out_ch.frame_done = res.frame_done;
  assign out_ch.row_count = res.row_count;

endmodule

[tb/dgs_tb_if.sv]
`timescale 1ns / 100ps
// The interfaces are supplied by the RTL in rtl/dgs_if.sv; this file holds a small
// helper package with the testbench's expected result beat type.
package dgs_tb_pkg;
  import dgs_pkg::*;
  // One expected result beat.
  typedef struct {
    logic               has_value;
    logic signed [40:0] stat_value;
    logic [15:0]        row_index;
    logic               frame_done;
    logic [15:0]        row_count;
  } stat_beat_t;
endpackage

[tb/dgs_checker.sv]
`timescale 1ns / 100ps
// Checker: watches the channels, predicts group statistics and compares results.
module dgs_checker (
  input logic clk,
  input logic rst,
  dgs_in_if        in_mon,
  dgs_out_if       out_mon,
  dgs_cfg_if       cfg_mon,
  output int       errors,
  output int       pending
);
  import dgs_pkg::*;
  import dgs_tb_pkg::*;

  localparam logic signed [63:0] SumMax = 64'sh000000FFFFFFFFFF;
  localparam logic signed [63:0] SumMin = -64'sh0000010000000000;

  logic [15:0] group_size, max_rows, in_group, rows_given;
  logic [2:0]  stat_mode;
  logic signed [63:0] run_value;
  logic [63:0] run_squares;
  stat_beat_t  expected_beats[$];

  // Integer square root by the classic bit-pair method.
  function automatic logic [63:0] int_sqrt(input logic [63:0] a);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > a) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (a >= res + bit_v) begin
        a = a - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Advance the predicted state by one accepted sample beat.
  task automatic take_sample(input logic signed [23:0] s, input logic last);
    logic signed [63:0] x, val, sum;
    logic [63:0] sq, n64;
    logic [15:0] n;
    logic have;
    stat_beat_t b;
    x = s;
    sq = (x < 0 ? -x : x) * (x < 0 ? -x : x);
    n = (group_size == 0) ? 16'd1 : group_size;
    n64 = n;
    have = 0;
    val = 0;
    b.row_index = 0;
    if (in_group == 0) begin
      run_value = x;
      run_squares = sq;
    end else begin
      if (stat_mode == MODE_MIN) begin
        if (x < run_value) run_value = x;
      end else if (stat_mode == MODE_MAX) begin
        if (x > run_value) run_value = x;
      end else begin
        sum = run_value + x;
        run_value = sum > SumMax ? SumMax : (sum < SumMin ? SumMin : sum);
      end
      run_squares = (run_squares > ~sq) ? '1 : run_squares + sq;
    end
    in_group++;
    if (in_group >= n) begin
      if (rows_given < max_rows) begin
        if (stat_mode == MODE_AVG) val = run_value / $signed(n64);
        else if (stat_mode == MODE_RMS) val = $signed(int_sqrt(run_squares / n64));
        else val = run_value;
        have = 1;
        b.row_index = rows_given;
        rows_given++;
      end
      in_group = 0;
      run_value = 0;
      run_squares = 0;
    end
    if (have || last) begin
      b.has_value = have;
      b.stat_value = have ? val[40:0] : '0;
      b.frame_done = last;
      b.row_count = last ? rows_given : '0;
      expected_beats = {expected_beats, b};
    end
    if (last) begin
      in_group = 0;
      run_value = 0;
      run_squares = 0;
      rows_given = 0;
    end
  endtask

  always @(posedge clk) begin
    stat_beat_t e;
    if (rst) begin
      group_size <= 16'd8;
      stat_mode <= MODE_AVG;
      max_rows <= 16'd1024;
      in_group = 0;
      rows_given = 0;
      run_value = 0;
      run_squares = 0;
      expected_beats.delete();
      errors = 0;
    end else begin
      // Register writes.
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_GROUP_SIZE: group_size <= cfg_mon.data;
          REG_STAT_MODE: stat_mode <= cfg_mon.data[2:0];
          REG_MAX_ROWS: max_rows <= cfg_mon.data;
          default: ;
        endcase
      end
      // Result beats against the oldest expectation.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_beats.size() == 0) begin
          report("unexpected beat", out_mon.stat_value, 0);
        end else begin
          e = expected_beats.pop_front();
          if (out_mon.has_value !== e.has_value)
            report("has_value", out_mon.has_value, e.has_value);
          if (out_mon.stat_value !== e.stat_value)
            report("stat_value", out_mon.stat_value, e.stat_value);
          if (out_mon.row_index !== e.row_index)
            report("row_index", out_mon.row_index, e.row_index);
          if (out_mon.frame_done !== e.frame_done)
            report("frame_done", out_mon.frame_done, e.frame_done);
          if (out_mon.row_count !== e.row_count)
            report("row_count", out_mon.row_count, e.row_count);
        end
      end
      // Sample beats.
      if (in_mon.valid && in_mon.ready) take_sample(in_mon.sample, in_mon.frame_end);
    end
    pending = expected_beats.size();
  end
endmodule

[tb/decimating_group_statistics_tb.sv]
`timescale 1ns / 100ps
// Testbench top: clock, reset, sample and register stimulus, and the verdict.
module decimating_group_statistics_tb;
  import dgs_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic out_ready = 0;
  logic calm = 0;
  int errors, pending;

  dgs_in_if #(.SampleBits(24)) in_ch (clk);
  dgs_out_if out_ch (clk);
  dgs_cfg_if cfg (clk);

  decimating_group_statistics dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );
  dgs_checker u_checker (.clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg),
                         .errors(errors), .pending(pending));

  always #5 clk = ~clk;
  assign out_ch.ready = out_ready;

  // Receiver stalls in bursts, none once the run is calm.
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 13);
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
    end
  end

  // Send one sample beat, with an occasional burst of idle cycles first.
  // Valid stays high after the beat so that samples can follow back to back.
  task automatic send_sample(input logic signed [23:0] s, input logic last);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.sample <= s;
    in_ch.frame_end <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Write one register; only called while the block is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  // Let every expected beat drain, then allow the back end to settle.
  task automatic drain;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] gs, input logic [2:0] mode, input logic [15:0] rows);
    in_ch.valid <= 0;
    drain();
    write_reg(REG_GROUP_SIZE, gs);
    write_reg(REG_STAT_MODE, {13'd0, mode});
    write_reg(REG_MAX_ROWS, rows);
    cfg.valid <= 0;
  endtask

  function automatic logic signed [23:0] rand_sample;
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'(int'($urandom_range(0, 15)) - 8);
      default: return 24'($urandom());
    endcase
  endfunction

  initial begin
    int frame_len, sent;
    logic [15:0] gs, rows;
    in_ch.valid = 0;
    in_ch.sample = 0;
    in_ch.frame_end = 0;
    cfg.valid = 0;
    cfg.index = REG_GROUP_SIZE;
    cfg.data = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset settings, extremes, every mode, zero group size, max_rows 0.
    for (int i = 0; i < 8; i++) send_sample(i[0] ? 24'sh800000 : 24'sh7FFFFF, i == 7);
    configure(16'd2, MODE_MIN, 16'd3);
    send_sample(24'sh7FFFFF, 0); send_sample(-24'sd5, 0);
    send_sample(24'sh800000, 0); send_sample(24'sd3, 1);
    configure(16'd2, MODE_MAX, 16'd1);
    send_sample(24'sd4, 0); send_sample(24'sh7FFFFF, 0); send_sample(24'sd1, 0);
    send_sample(24'sd2, 0); send_sample(24'sd9, 1);
    configure(16'd3, MODE_RMS, 16'hFFFF);
    send_sample(24'sh800000, 0); send_sample(24'sh800000, 0); send_sample(24'sh7FFFFF, 1);
    configure(16'd0, MODE_SUM, 16'd0);
    send_sample(24'sd7, 0); send_sample(24'sd1, 1);
    configure(16'd0, 3'd7, 16'd5);
    send_sample(-24'sd7, 0); send_sample(24'sh800000, 1);
    configure(16'hFFFF, 3'd5, 16'd2);
    send_sample(24'sd1, 1);

    // Random phases: mostly small groups, with new settings only between frames.
    sent = 0;
    while (sent < 1500) begin
      if (sent > 1200) calm = 1;
      gs = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 40))
                                       : 16'($urandom_range(0, 6));
      rows = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 2))
                                         : 16'($urandom_range(3, 65535));
      configure(gs, 3'($urandom_range(0, 7)), rows);
      for (int f = 0; f < 3; f++) begin
        frame_len = $urandom_range(1, 40);
        for (int k = 0; k < frame_len; k++) begin
          send_sample(rand_sample(), k == frame_len - 1);
          sent++;
        end
      end
    end

    in_ch.valid <= 0;
    drain();
    if (errors == 0) $display("decimating_group_statistics test passed");
    else $display("decimating_group_statistics test failed");
    $finish;
  end

  initial begin
    #50ms;
    $display("decimating_group_statistics test failed");
    $finish;
  end
endmodule
